### hdl/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg
// Shared types and constants of the substring match finder: widths, limits,
// configuration register indexes and the result record.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int PAT_MAX   = 8;
  localparam int BYTE_W    = 8;
  localparam int WIN_CELLS = PAT_MAX - 1;
  localparam int LEN_W     = 4;
  localparam int SEL_W     = 3;
  localparam int POS_W     = 16;
  localparam int CNT_W     = 10;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 1;

  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(PAT_MAX);
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);
  localparam logic [POS_W-1:0] POS_LIMIT = {POS_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(1023);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES  = 1'b0,
    CFG_PATTERN_LENGTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             match_found;
    logic [POS_W-1:0] match_start;
    logic [CNT_W-1:0] match_total;
    logic             text_done;
  } result_t;

endpackage

### hdl/smf_cell.sv
// ----------------------------------------------------------------------------
// smf_cell
// One window cell: holds one recent text byte, hands it to the next cell on
// every accepted request, and compares it against its pattern byte.
// ----------------------------------------------------------------------------
module smf_cell (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic [smf_pkg::BYTE_W-1:0] byte_in,
  input  logic [smf_pkg::BYTE_W-1:0] pat_byte,
  input  logic                      in_use,
  output logic [smf_pkg::BYTE_W-1:0] byte_out,
  output logic                      hit
);

  logic [smf_pkg::BYTE_W-1:0] byte_r;
  logic [smf_pkg::BYTE_W-1:0] byte_nxt;

  assign byte_nxt = shift_en ? byte_in : byte_r;

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_out = byte_r;
  // cells past the pattern length never veto a match
  assign hit      = !in_use || (byte_r == pat_byte);

endmodule

### hdl/smf_out_buf.sv
// ----------------------------------------------------------------------------
// smf_out_buf
// Two-entry result buffer: an output register backed by a skid register, so
// the input side keeps taking requests while a result waits downstream.
// ----------------------------------------------------------------------------
module smf_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              push_ready,
  input  smf_pkg::result_t  push_data,
  output logic              out_valid,
  input  logic              out_ready,
  output smf_pkg::result_t  out_data
);

  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             skid_valid_r;
  logic             skid_valid_nxt;
  smf_pkg::result_t out_data_r;
  smf_pkg::result_t out_data_nxt;
  smf_pkg::result_t skid_data_r;
  smf_pkg::result_t skid_data_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (push) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = push_data;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = push_data;
      end
    end else if (out_valid_r && out_ready) begin
      // advance the skid entry or drain
      out_valid_nxt  = skid_valid_r;
      out_data_nxt   = skid_data_r;
      skid_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_skid_drains_first: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry not moved to output register");
`endif

endmodule

### hdl/substring_match_finder.sv
// ----------------------------------------------------------------------------
// substring_match_finder
// Streaming search for non-overlapping occurrences of a configured pattern
// of up to eight bytes in a byte text, one result per text byte.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while the output buffer has room and returns
// one result per byte, held in the output buffer. The last seven bytes sit in
// a row of window cells that shift on every accepted request; the pattern is
// compared against the window and the incoming byte in parallel in that same
// cycle, so the rate is one byte per clock. Results pass through a two-entry
// output buffer, so the input keeps flowing while one result waits. A match
// reports its start position and the running count; start positions inside
// the previous match are skipped. All text state clears after the byte
// flagged as last. Write the pattern registers only while the block is idle.
module substring_match_finder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [smf_pkg::BYTE_W-1:0]    in_text_byte,
  input  logic                          in_is_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_match_found,
  output logic [smf_pkg::POS_W-1:0]     out_match_start,
  output logic [smf_pkg::CNT_W-1:0]     out_match_total,
  output logic                          out_text_done,
  input  logic                          cfg_wr_en,
  input  logic [smf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smf_pkg::CFG_W-1:0]     cfg_wr_data
);

  logic [smf_pkg::CFG_W-1:0] pattern_r;
  logic [smf_pkg::CFG_W-1:0] pattern_nxt;
  logic [smf_pkg::LEN_W-1:0] pat_len_r;
  logic [smf_pkg::LEN_W-1:0] pat_len_nxt;

  logic [smf_pkg::POS_W-1:0] pos_r;
  logic [smf_pkg::POS_W-1:0] pos_nxt;
  logic [smf_pkg::POS_W-1:0] nas_r;
  logic [smf_pkg::POS_W-1:0] nas_nxt;
  logic [smf_pkg::CNT_W-1:0] cnt_r;
  logic [smf_pkg::CNT_W-1:0] cnt_nxt;

  logic                      in_fire;
  logic [smf_pkg::LEN_W-1:0] len_eff;
  logic [smf_pkg::PAT_MAX-1:0]     use_k;
  logic [smf_pkg::PAT_MAX-1:0]     hits;
  logic [smf_pkg::BYTE_W-1:0]      pat_sel [smf_pkg::PAT_MAX];
  logic [smf_pkg::BYTE_W-1:0]      win_byte [smf_pkg::PAT_MAX];
  logic [smf_pkg::SEL_W-1:0]       sel_idx;
  logic [smf_pkg::LEN_W-1:0]       sel_full;
  logic [smf_pkg::POS_W:0]         pos_plus1;
  logic [smf_pkg::POS_W:0]         start_full;
  logic [smf_pkg::POS_W-1:0]       start_c;
  logic                            enough_c;
  logic                            found_c;
  logic [smf_pkg::CNT_W-1:0]       cnt_upd;
  smf_pkg::result_t                res_c;
  smf_pkg::result_t                res_out;

  // configuration registers
  always_comb begin
    pattern_nxt = pattern_r;
    pat_len_nxt = pat_len_r;
    if (cfg_wr_en) begin
      unique case (smf_pkg::cfg_reg_t'(cfg_index))
        smf_pkg::CFG_PATTERN_BYTES:  pattern_nxt = cfg_wr_data;
        smf_pkg::CFG_PATTERN_LENGTH: pat_len_nxt = cfg_wr_data[smf_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      pat_len_r <= smf_pkg::LEN_RESET;
    end else begin
      pattern_r <= pattern_nxt;
      pat_len_r <= pat_len_nxt;
    end
  end

  assign in_fire = in_valid && in_ready;
  assign len_eff = (pat_len_r > smf_pkg::LEN_MAX) ? smf_pkg::LEN_MAX : pat_len_r;

  // recent byte k lines up with pattern byte len-1-k
  always_comb begin
    for (int k = 0; k < smf_pkg::PAT_MAX; k++) begin
      sel_full   = len_eff - smf_pkg::LEN_W'(1) - smf_pkg::LEN_W'(k);
      sel_idx    = sel_full[smf_pkg::SEL_W-1:0];
      use_k[k]   = smf_pkg::LEN_W'(k) < len_eff;
      pat_sel[k] = pattern_r[{sel_idx, 3'b000} +: smf_pkg::BYTE_W];
    end
  end

  assign win_byte[0] = in_text_byte;
  assign hits[0]     = !use_k[0] || (in_text_byte == pat_sel[0]);

  for (genvar k = 1; k < smf_pkg::PAT_MAX; k++) begin : g_cell
    smf_cell u_cell (
      .clk      (clk),
      .shift_en (in_fire),
      .byte_in  (win_byte[k-1]),
      .pat_byte (pat_sel[k]),
      .in_use   (use_k[k]),
      .byte_out (win_byte[k]),
      .hit      (hits[k])
    );
  end

  assign pos_plus1  = {1'b0, pos_r} + (smf_pkg::POS_W+1)'(1);
  assign enough_c   = pos_plus1 >= (smf_pkg::POS_W+1)'(len_eff);
  assign start_full = pos_plus1 - (smf_pkg::POS_W+1)'(len_eff);
  assign start_c    = start_full[smf_pkg::POS_W-1:0];
  assign found_c    = (len_eff != '0) && enough_c && (&hits) && (start_c >= nas_r);
  assign cnt_upd    = (found_c && (cnt_r != smf_pkg::COUNT_MAX)) ?
                      cnt_r + smf_pkg::CNT_W'(1) : cnt_r;

  always_comb begin
    pos_nxt = pos_r;
    nas_nxt = nas_r;
    cnt_nxt = cnt_r;
    if (in_fire) begin
      if (in_is_last) begin
        pos_nxt = '0;
        nas_nxt = '0;
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_upd;
        if (pos_r != smf_pkg::POS_LIMIT) begin
          pos_nxt = pos_r + smf_pkg::POS_W'(1);
        end
        if (found_c) begin
          nas_nxt = (pos_r != smf_pkg::POS_LIMIT) ? pos_r + smf_pkg::POS_W'(1) : pos_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      nas_r <= '0;
      cnt_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      nas_r <= nas_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    res_c.match_found = found_c;
    res_c.match_start = found_c ? start_c : '0;
    res_c.match_total = cnt_upd;
    res_c.text_done   = in_is_last;
  end

  smf_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_ready (in_ready),
    .push_data  (res_c),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (res_out)
  );

  assign out_match_found = res_out.match_found;
  assign out_match_start = res_out.match_start;
  assign out_match_total = res_out.match_total;
  assign out_text_done   = res_out.text_done;

`ifndef SYNTHESIS
  a_start_not_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    nas_r <= pos_r)
    else $error("next allowed start ran past byte position");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_is_last) |=> (pos_r == '0 && nas_r == '0 && cnt_r == '0))
    else $error("text state not cleared after last byte");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_is_last) |=> (cnt_r >= $past(cnt_r)))
    else $error("match count decreased within a text");

  a_match_sets_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_is_last && found_c && pos_r != smf_pkg::POS_LIMIT)
      |=> (nas_r == pos_r))
    else $error("next allowed start not moved past match");
`endif

endmodule

### verif/substring_match_finder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// substring_match_finder_tb
// Self-checking bench for the substring match finder. Drives text bytes over
// the request channel, predicts every result in a scoreboard that tracks the
// window, position, skip point and count, and checks results field by field
// under random idling on both sides and a sequence of pattern settings.
// ----------------------------------------------------------------------------
module substring_match_finder_tb;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 650;

  typedef logic [smf_pkg::BYTE_W-1:0] text_q_t[$];

  class smf_scoreboard;
    logic [smf_pkg::CFG_W-1:0]                     pattern_reg    = '0;
    logic [smf_pkg::LEN_W-1:0]                     length_reg     = smf_pkg::LEN_RESET;
    logic [smf_pkg::WIN_CELLS*smf_pkg::BYTE_W-1:0] window         = '0;
    logic [smf_pkg::POS_W-1:0]                     position       = '0;
    logic [smf_pkg::POS_W-1:0]                     earliest_start = '0;
    logic [smf_pkg::CNT_W-1:0]                     found          = '0;
    smf_pkg::result_t                              expected_q[$];
    int errors     = 0;
    int checked    = 0;
    int match_seen = 0;

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(smf_pkg::cfg_reg_t idx, logic [smf_pkg::CFG_W-1:0] data);
      case (idx)
        smf_pkg::CFG_PATTERN_BYTES:  pattern_reg = data;
        smf_pkg::CFG_PATTERN_LENGTH: length_reg  = data[smf_pkg::LEN_W-1:0];
        default: ;
      endcase
    endfunction

    // Predict the result of one accepted text byte and advance the text state.
    function void note_request(logic [smf_pkg::BYTE_W-1:0] b, logic last);
      int                        len;
      int                        j;
      int                        start_pos;
      bit                        same;
      logic [smf_pkg::CFG_W-1:0] recent;
      smf_pkg::result_t          r;
      len = (length_reg > smf_pkg::LEN_MAX) ? smf_pkg::PAT_MAX : int'(length_reg);
      r = '0;
      if (len != 0 && int'(position) + 1 >= len) begin
        recent = {window, b};
        same = 1'b1;
        for (j = 0; j < len; j++) begin
          if (pattern_reg[8*j +: 8] != recent[8*(len-1-j) +: 8]) same = 1'b0;
        end
        start_pos = int'(position) + 1 - len;
        if (same && start_pos >= int'(earliest_start)) begin
          r.match_found = 1'b1;
          r.match_start = start_pos[smf_pkg::POS_W-1:0];
          if (found < smf_pkg::COUNT_MAX) found++;
          earliest_start = (position < smf_pkg::POS_LIMIT) ? position + 1'b1 :
                           smf_pkg::POS_LIMIT;
        end
      end
      r.match_total = found;
      r.text_done   = last;
      expected_q.push_back(r);
      if (last) begin
        window         = '0;
        position       = '0;
        earliest_start = '0;
        found          = '0;
      end else begin
        window = {window[(smf_pkg::WIN_CELLS-1)*smf_pkg::BYTE_W-1:0], b};
        if (position < smf_pkg::POS_LIMIT) position++;
      end
    endfunction

    function void report(string what, logic [31:0] exp_val, logic [31:0] act_val);
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_val, act_val);
    endfunction

    function void check_result(smf_pkg::result_t got);
      smf_pkg::result_t exp_r;
      if (expected_q.size() == 0) begin
        report("unrequested result", 32'd0, 32'd1);
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (exp_r.match_found) match_seen++;
      if (got.match_found !== exp_r.match_found)
        report("match_found", 32'(exp_r.match_found), 32'(got.match_found));
      if (got.match_start !== exp_r.match_start)
        report("match_start", 32'(exp_r.match_start), 32'(got.match_start));
      if (got.match_total !== exp_r.match_total)
        report("match_total", 32'(exp_r.match_total), 32'(got.match_total));
      if (got.text_done !== exp_r.text_done)
        report("text_done", 32'(exp_r.text_done), 32'(got.text_done));
    endfunction
  endclass

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          in_valid     = 1'b0;
  logic                          in_ready;
  logic [smf_pkg::BYTE_W-1:0]    in_text_byte = '0;
  logic                          in_is_last   = 1'b0;
  logic                          out_valid;
  logic                          out_ready    = 1'b0;
  logic                          out_match_found;
  logic [smf_pkg::POS_W-1:0]     out_match_start;
  logic [smf_pkg::CNT_W-1:0]     out_match_total;
  logic                          out_text_done;
  logic                          cfg_wr_en    = 1'b0;
  logic [smf_pkg::CFG_IDX_W-1:0] cfg_index    = smf_pkg::CFG_PATTERN_BYTES;
  logic [smf_pkg::CFG_W-1:0]     cfg_wr_data  = '0;

  smf_scoreboard sb = new;

  int idle_max_in      = 0;
  int idle_max_out     = 0;
  int bytes_sent       = 0;
  int settings_used    = 0;
  bit drain_enable     = 1'b0;
  bit drained_mid_text = 1'b0;

  substring_match_finder u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_is_last      (in_is_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_match_found (out_match_found),
    .out_match_start (out_match_start),
    .out_match_total (out_match_total),
    .out_text_done   (out_text_done),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin : bus_monitor
    smf_pkg::result_t got;
    if (rst_n) begin
      // Note first so a same-edge result still finds its expectation.
      if (in_valid && in_ready) sb.note_request(in_text_byte, in_is_last);
      if (out_valid && out_ready) begin
        got.match_found = out_match_found;
        got.match_start = out_match_start;
        got.match_total = out_match_total;
        got.text_done   = out_text_done;
        sb.check_result(got);
      end
    end
  end

  initial begin : result_sink
    int gap;
    forever begin
      gap = $urandom_range(0, idle_max_out);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
    $display("substring_match_finder regression: fail");
    $finish;
  end

  // Drop the request and hold until every predicted result has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_byte(input logic [smf_pkg::BYTE_W-1:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, idle_max_in);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    in_is_last   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input text_q_t txt);
    int i;
    for (i = 0; i < txt.size(); i++) begin
      if (drain_enable && i > 0 && (!drained_mid_text || $urandom_range(0, 39) == 0)) begin
        wait_results_drained();
        drained_mid_text = 1'b1;
      end
      send_byte(txt[i], i == txt.size() - 1);
    end
  endtask

  task automatic set_pattern(input logic [smf_pkg::CFG_W-1:0] pat,
                             input logic [smf_pkg::CFG_W-1:0] len_word);
    wait_results_drained();
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= smf_pkg::CFG_PATTERN_BYTES;
    cfg_wr_data <= pat;
    @(posedge clk);
    cfg_index   <= smf_pkg::CFG_PATTERN_LENGTH;
    cfg_wr_data <= len_word;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(smf_pkg::CFG_PATTERN_BYTES, pat);
    sb.write_reg(smf_pkg::CFG_PATTERN_LENGTH, len_word);
    settings_used++;
  endtask

  initial begin : main
    text_q_t                    txt;
    logic [smf_pkg::CFG_W-1:0]  pat;
    logic [smf_pkg::CFG_W-1:0]  len_word;
    logic [smf_pkg::LEN_W-1:0]  plen;
    logic [smf_pkg::BYTE_W-1:0] alpha_a;
    logic [smf_pkg::BYTE_W-1:0] alpha_b;
    int eff_len;
    int text_len;
    int n_texts;
    int pick;
    int k;
    int random_items;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset pattern is a single zero byte: zero bytes compare literally.
    idle_max_in  = 2;
    idle_max_out = 2;
    txt = '{8'h00, 8'hFF};
    send_text(txt);

    // Overlapping candidate is skipped; first bytes are too few to match.
    set_pattern(64'h0000_0000_0041_4241, 64'd3);
    txt = '{8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42, 8'h41};
    send_text(txt);

    // Zero length never matches.
    set_pattern(64'd0, 64'd0);
    txt = '{8'h00, 8'h00, 8'h00};
    send_text(txt);

    // Length above the maximum is clamped to eight.
    set_pattern({smf_pkg::CFG_W{1'b1}}, 64'd15);
    txt = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_text(txt);

    // Random phases: planted patterns, broken prefixes, alphabet and noise bytes.
    drain_enable = 1'b1;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       plen = '0;
        1:       plen = smf_pkg::LEN_W'(1);
        2:       plen = smf_pkg::LEN_MAX;
        3:       plen = smf_pkg::LEN_W'($urandom_range(smf_pkg::PAT_MAX + 1, 15));
        default: plen = smf_pkg::LEN_W'($urandom_range(1, smf_pkg::PAT_MAX));
      endcase
      len_word = 64'(plen);
      if ($urandom_range(0, 3) == 0) len_word = {$urandom, 28'($urandom), plen};
      eff_len = (plen > smf_pkg::LEN_MAX) ? smf_pkg::PAT_MAX : int'(plen);

      if ($urandom_range(0, 7) == 0) begin
        alpha_a = 8'h00;
        alpha_b = 8'hFF;
      end else begin
        alpha_a = 8'($urandom_range(0, 255));
        alpha_b = 8'($urandom_range(0, 255));
      end
      case ($urandom_range(0, 9))
        0:       pat = '0;
        1:       pat = {smf_pkg::CFG_W{1'b1}};
        2:       pat = {$urandom, $urandom};
        default: begin
          for (k = 0; k < smf_pkg::PAT_MAX; k++)
            pat[8*k +: 8] = ($urandom_range(0, 1) != 0) ? alpha_a : alpha_b;
        end
      endcase

      case ($urandom_range(0, 2))
        0:       idle_max_in = 0;
        1:       idle_max_in = 10;
        default: idle_max_in = $urandom_range(1, 10);
      endcase
      case ($urandom_range(0, 2))
        0:       idle_max_out = 0;
        1:       idle_max_out = 10;
        default: idle_max_out = $urandom_range(1, 10);
      endcase

      set_pattern(pat, len_word);
      n_texts = $urandom_range(1, 4);
      repeat (n_texts) begin
        text_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
        txt.delete();
        while (txt.size() < text_len) begin
          pick = $urandom_range(0, 99);
          if (eff_len != 0 && pick < 30) begin
            for (k = 0; k < eff_len; k++) txt.push_back(pat[8*k +: 8]);
          end else if (eff_len > 1 && pick < 40) begin
            // Break the pattern off after a prefix.
            for (k = 0; k < $urandom_range(1, eff_len - 1); k++) txt.push_back(pat[8*k +: 8]);
            txt.push_back(8'($urandom_range(0, 255)));
          end else if (pick < 80) begin
            txt.push_back(($urandom_range(0, 1) != 0) ? alpha_a : alpha_b);
          end else begin
            txt.push_back(8'($urandom_range(0, 255)));
          end
        end
        send_text(txt);
        random_items += txt.size();
      end
    end

    wait_results_drained();
    repeat (8) @(posedge clk);
    sb.errors += sb.pending();

    $display("checked %0d results from %0d text bytes under %0d pattern settings, %0d matches",
             sb.checked, bytes_sent, settings_used, sb.match_seen);
    $display("covered zero and clamped lengths, zero bytes, overlap skip and stalls both sides");
    if (sb.errors == 0) begin
      $display("substring_match_finder regression: pass");
    end else begin
      $display("substring_match_finder regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/smf_pkg.sv
hdl/smf_cell.sv
hdl/smf_out_buf.sv
hdl/substring_match_finder.sv
verif/substring_match_finder_tb.sv
